### design/hstp_pkg.sv
// Package for the hashed symbol table probe unit.
// Holds the table geometry, the result and state codes and the home-slot hash.
// No dependencies.
package hstp_pkg;

  localparam int TABLE_SLOTS = 511;
  localparam int NAME_CHARS  = 6;
  localparam int CHAR_W      = 7;
  localparam int NAME_W      = CHAR_W * NAME_CHARS;
  localparam int FLAG_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int MEM_W       = NAME_W + FLAG_W;

  // Probe step width: the step runs up to TABLE_SLOTS before it stops.
  localparam int STEP_W      = $clog2(TABLE_SLOTS + 2);
  localparam int PSUM_W      = STEP_W + 1;

  localparam int CHAR_MAX    = (1 << CHAR_W) - 1;
  localparam int SUM_MAX     = (NAME_CHARS / 2) * ((CHAR_MAX << 7) + (CHAR_MAX << 1));
  localparam int SUM_W       = $clog2(SUM_MAX + 1);

  // Home-slot reduction by reciprocal multiplication. The reciprocal is
  // rounded down, so the quotient estimate is exact or one short and a single
  // compare and subtract finishes the remainder.
  localparam int RECIP_SH    = SUM_W + SLOT_W;
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QUOT_W      = SUM_W - SLOT_W + 1;
  localparam longint unsigned RECIP_FULL = (64'd1 << RECIP_SH) / TABLE_SLOTS;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP_FULL);

  localparam logic [FLAG_W-1:0] FLAG_RELOC  = 3'b001;
  localparam logic [FLAG_W-1:0] FLAG_ENTRY  = 3'b010;
  localparam logic [FLAG_W-1:0] FLAG_EXTERN = 3'b100;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE
  } state_e;

  // Sum over character pairs: first character shifted by 7, second by 1.
  // An unpaired last character does not take part.
  function automatic logic [SUM_W-1:0] home_sum(input logic [NAME_W-1:0] name);
    logic [SUM_W-1:0] sum;
    logic [CHAR_W-1:0] c_hi;
    logic [CHAR_W-1:0] c_lo;
    sum = '0;
    for (int i = 0; i < NAME_CHARS / 2; i++) begin
      c_hi = name[NAME_W - 1 - CHAR_W * (2 * i) -: CHAR_W];
      c_lo = name[NAME_W - 1 - CHAR_W * (2 * i + 1) -: CHAR_W];
      sum  = sum + (SUM_W'(c_hi) << 7) + (SUM_W'(c_lo) << 1);
    end
    return sum;
  endfunction

endpackage

### design/hashed_symbol_table_probe_unit.sv
// Hashed symbol table probe unit: top level.
// Holds the slot memory, the home-slot reduction and the probe sequencer.
// Depends on hstp_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one beat per request:
//   a lookup or an add, with the symbol name and the marks for a new entry.
//   The output channel (out_valid_o / out_ready_i) returns one beat per
//   request: found, missed (with the free slot, filled on an add) or full.
//   Requests are handled one at a time. After the accept cycle the home
//   slot is reduced modulo the slot count (a reciprocal multiply for the
//   quotient, then a multiply-back and one compare and subtract); the
//   second of these steps issues the first read. Each probe then uses the
//   single read port of the slot memory. The next request is accepted once
//   the last one has handed its result to the output register. A lightly
//   loaded table needs one or two probes. A full table costs one probe per
//   odd step, about TABLE_SLOTS / 2 probes.
//   After reset the slot memory is cleared one slot per cycle, and
//   in_ready_o stays low until that pass is done.
//   The result sits in an output register. While the receiver stalls with
//   a result still held, a new request can be accepted and worked on; it
//   waits in its last probe until the register frees up.
module hashed_symbol_table_probe_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [hstp_pkg::NAME_W-1:0]     symbol_name_i,
  input  logic                            entry_mark_i,
  input  logic                            external_mark_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [hstp_pkg::STATUS_W-1:0]   status_o,
  output logic [hstp_pkg::SLOT_W-1:0]     slot_index_o,
  output logic [hstp_pkg::FLAG_W-1:0]     entry_flags_o
);
  import hstp_pkg::*;

  state_e               state_q, state_d;
  logic [SLOT_W-1:0]    clear_q, clear_d;
  logic                 k_q, k_d;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [SLOT_W-1:0]    h_q, h_d;
  logic [STEP_W-1:0]    d_q, d_d;

  logic                 kind_q;
  logic [NAME_W-1:0]    name_q;
  logic                 ent_q;
  logic                 ext_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [FLAG_W-1:0]    flags_q;

  logic [MEM_W-1:0]     mem [TABLE_SLOTS];
  logic [MEM_W-1:0]     rd_q;
  logic                 mem_re;
  logic [SLOT_W-1:0]    mem_raddr;
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_waddr;
  logic [MEM_W-1:0]     mem_wdata;

  logic                 accept;
  logic                 finish;
  logic                 out_free;
  status_e              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [FLAG_W-1:0]    res_flags;

  logic [PROD_W-1:0]    recip_prod;
  logic [SUM_W-1:0]     quot_back;
  logic [SUM_W-1:0]     rem_diff;
  logic [SLOT_W-1:0]    home_slot;
  logic [NAME_W-1:0]    rd_name;
  logic [FLAG_W-1:0]    rd_flags;
  logic [FLAG_W-1:0]    new_flags;
  logic                 slot_empty;
  logic                 slot_match;
  logic [PSUM_W-1:0]    h_sum;
  logic [SLOT_W-1:0]    h_next;
  logic [STEP_W-1:0]    d_next;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;

  // Quotient estimate while k_q is set, remainder fix-up once it has cleared.
  assign recip_prod = PROD_W'(rem_q) * PROD_W'(RECIP_M);
  assign quot_back  = SUM_W'(quot_q) * SUM_W'(TABLE_SLOTS);
  assign rem_diff   = rem_q - quot_back;
  assign home_slot  = (rem_diff >= SUM_W'(TABLE_SLOTS)) ? SLOT_W'(rem_diff - SUM_W'(TABLE_SLOTS))
                                                        : SLOT_W'(rem_diff);

  assign rd_name    = rd_q[NAME_W-1:0];
  assign rd_flags   = rd_q[MEM_W-1:NAME_W];
  assign slot_empty = (rd_name[NAME_W-1 -: CHAR_W] == '0);
  assign slot_match = (rd_name == name_q);
  assign new_flags  = FLAG_RELOC | (ent_q ? FLAG_ENTRY : '0) | (ext_q ? FLAG_EXTERN : '0);

  // Next probe position; both terms stay below TABLE_SLOTS, so one wrap.
  assign h_sum  = PSUM_W'(h_q) + PSUM_W'(d_q);
  assign h_next = (h_sum >= PSUM_W'(TABLE_SLOTS)) ? SLOT_W'(h_sum - PSUM_W'(TABLE_SLOTS))
                                                  : SLOT_W'(h_sum);
  assign d_next = d_q + STEP_W'(2);

  always_comb begin
    state_d    = state_q;
    clear_d    = clear_q;
    k_d        = k_q;
    rem_d      = rem_q;
    quot_d     = quot_q;
    h_d        = h_q;
    d_d        = d_q;
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = h_q;
    mem_we     = 1'b0;
    mem_waddr  = h_q;
    mem_wdata  = {new_flags, name_q};
    finish     = 1'b0;
    res_status = ST_FULL;
    res_slot   = '0;
    res_flags  = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_q;
        mem_wdata = '0;
        if (clear_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clear_d = clear_q + SLOT_W'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rem_d   = home_sum(symbol_name_i);
          k_d     = 1'b1;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (k_q) begin
          quot_d = QUOT_W'(recip_prod >> RECIP_SH);
          k_d    = 1'b0;
        end else begin
          // The remainder is final here: start the first probe.
          h_d       = home_slot;
          d_d       = STEP_W'(1);
          mem_re    = 1'b1;
          mem_raddr = home_slot;
          state_d   = S_PROBE;
        end
      end
      S_PROBE: begin
        if (slot_empty) begin
          res_status = ST_MISS;
          res_slot   = h_q;
          res_flags  = kind_q ? new_flags : rd_flags;
          if (out_free) begin
            finish  = 1'b1;
            mem_we  = kind_q;
            state_d = S_IDLE;
          end
        end else if (slot_match) begin
          res_status = ST_FOUND;
          res_slot   = h_q;
          res_flags  = rd_flags;
          if (out_free) begin
            finish  = 1'b1;
            state_d = S_IDLE;
          end
        end else if (d_next >= STEP_W'(TABLE_SLOTS)) begin
          if (out_free) begin
            finish  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          h_d       = h_next;
          d_d       = d_next;
          mem_re    = 1'b1;
          mem_raddr = h_next;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clear_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clear_q     <= '0;
      k_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clear_q <= clear_d;
      k_q     <= k_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    h_q    <= h_d;
    d_q    <= d_d;
    if (accept) begin
      kind_q <= kind_i;
      name_q <= symbol_name_i;
      ent_q  <= entry_mark_i;
      ext_q  <= external_mark_i;
    end
    if (finish) begin
      status_q <= res_status;
      slot_q   <= res_slot;
      flags_q  <= res_flags;
    end
  end

  // Slot memory. Only one item is in flight and its write comes at the end
  // of its last probe, so no read ever overlaps a write to the same slot.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_index_o  = slot_q;
  assign entry_flags_o = flags_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("slot memory read and write in the same cycle");

  a_full_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (slot_index_o == '0 && entry_flags_o == '0))
    else $error("table full result carries a slot or flags");

  a_step_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (d_q[0] && d_q < STEP_W'(TABLE_SLOTS)))
    else $error("probe step is not odd or has run past the table");

  a_add_sets_reloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_PROBE) |=> (out_valid_o && status_o == ST_MISS && entry_flags_o[0]))
    else $error("added slot result lacks the relocatable flag");

endmodule
